[src/crp_pkg.sv]
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants for the clock page replacement block.
// ----------------------------------------------------------------------------
package crp_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SLOTS_DEF = 16;
  localparam int KEY_BITS_DEF  = 32;

  // Fixed field widths.
  localparam int CAP_W  = 5;
  localparam int SLOT_W = 4;
  localparam int EVK_W  = 32;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Outcome of one access.
  typedef enum logic [1:0] {
    KIND_HIT   = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_EVICT = 2'd2
  } res_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic set_hit;
    logic set_fill;
    logic set_sweep;
    logic clear_adv;
    logic grab_victim;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic match;
    logic last;
    logic room;
    logic ref_set;
    logic out_free;
  } dp_stat_t;

endpackage

[src/crp_in_if.sv]
// ----------------------------------------------------------------------------
// crp_in_if
// Access channel: one word carries a key and the reference bit for a new entry.
// ----------------------------------------------------------------------------
interface crp_in_if #(
  parameter int KEY_W = crp_pkg::KEY_BITS_DEF
);
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;
  logic             insert_ref;

  modport source (output valid, output key, output insert_ref, input ready);
  modport sink   (input valid, input key, input insert_ref, output ready);
endinterface

[src/crp_out_if.sv]
// ----------------------------------------------------------------------------
// crp_out_if
// Result channel: one word per access with hit, slot and eviction details.
// ----------------------------------------------------------------------------
interface crp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [crp_pkg::SLOT_W-1:0] slot;
  logic                       evicted;
  logic [crp_pkg::EVK_W-1:0]  evicted_key;

  modport source (output valid, output hit, output slot, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input slot, input evicted,
                  input evicted_key, output ready);
endinterface

[src/clock_page_replacement.sv]
// ----------------------------------------------------------------------------
// clock_page_replacement
// Clock (second-chance) replacement over a set of key slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one access word (key, insert_ref); out_ch returns one word
//   per access (hit, slot, evicted, evicted_key). cfg_we/cfg_wdata write the
//   capacity, which should only change while no access is in flight.
//   Keys are searched one slot per cycle in a key RAM with one read port,
//   and the clock hand also steps one slot per cycle over the reference bits.
//   With n occupied slots an access is accepted, searched over up to n slots
//   and then committed: a hit ends the search at its slot, a fill follows a
//   full search, and a replacement adds a sweep in which the hand clears s
//   (0 to n) set reference bits, then a victim read before the commit.
//   One access is in work at a time; the next is accepted as soon as the
//   previous one commits, even if its result word is still waiting.
//   Reset empties all slots, clears the reference bits and the hand, and sets
//   the capacity to 16. No clearing pass is needed after reset.
//   If out_ch stalls, the finished result stays in the output register and
//   the following access waits at its commit cycle.
// ----------------------------------------------------------------------------
module clock_page_replacement #(
  parameter int MAX_SLOTS = crp_pkg::MAX_SLOTS_DEF,
  parameter int KEY_BITS  = crp_pkg::KEY_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  crp_in_if.sink                    in_ch,
  crp_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [crp_pkg::CAP_W-1:0] cfg_wdata
);

  crp_pkg::dp_cmd_t  cmd;
  crp_pkg::dp_stat_t stat;
  logic              in_ready;

  // Sequencer.
  crp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  assign in_ch.ready = in_ready;

  // Storage and result datapath.
  crp_dp #(
    .MAX_SLOTS(MAX_SLOTS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_key         (in_ch.key),
    .in_insert_ref  (in_ch.insert_ref),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_hit        (out_ch.hit),
    .out_slot       (out_ch.slot),
    .out_evicted    (out_ch.evicted),
    .out_evicted_key(out_ch.evicted_key)
  );

endmodule

[src/crp_ram.sv]
// ----------------------------------------------------------------------------
// crp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crp_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[src/crp_ctrl.sv]
// ----------------------------------------------------------------------------
// crp_ctrl
// Sequencer for one access: key search, clock sweep, victim read and commit.
// ----------------------------------------------------------------------------
module crp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  crp_pkg::dp_stat_t stat,
  output crp_pkg::dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SEARCH = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_VICTIM = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.empty) begin
            // Nothing stored yet, so the key goes straight into slot zero.
            cmd.set_fill = 1'b1;
            state_nxt    = ST_FINISH;
          end else begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (stat.match) begin
          cmd.set_hit = 1'b1;
          state_nxt   = ST_FINISH;
        end else if (stat.last) begin
          if (stat.room) begin
            cmd.set_fill = 1'b1;
            state_nxt    = ST_FINISH;
          end else begin
            cmd.set_sweep = 1'b1;
            state_nxt     = ST_SWEEP;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (stat.ref_set) begin
          cmd.clear_adv = 1'b1;
        end else begin
          state_nxt = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        cmd.grab_victim = 1'b1;
        state_nxt       = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

[src/crp_dp.sv]
// ----------------------------------------------------------------------------
// crp_dp
// Datapath: key RAM, reference bits, fill count, clock hand and result word.
// ----------------------------------------------------------------------------
module crp_dp #(
  parameter int MAX_SLOTS = crp_pkg::MAX_SLOTS_DEF,
  parameter int KEY_BITS  = crp_pkg::KEY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [crp_pkg::CAP_W-1:0]  cfg_wdata,
  input  logic [KEY_BITS-1:0]        in_key,
  input  logic                       in_insert_ref,
  input  crp_pkg::dp_cmd_t           cmd,
  output crp_pkg::dp_stat_t          stat,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [crp_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_evicted,
  output logic [crp_pkg::EVK_W-1:0]  out_evicted_key
);

  localparam int IdxW  = $clog2(MAX_SLOTS);
  localparam int CntW  = $clog2(MAX_SLOTS + 1);
  localparam int CapW  = crp_pkg::CAP_W;
  localparam int CmpW  = (CntW > CapW) ? CntW : CapW;
  localparam int SlotW = crp_pkg::SLOT_W;
  localparam int EvkW  = crp_pkg::EVK_W;

  logic [CapW-1:0]        cap_r, cap_nxt;
  logic [CntW-1:0]        fill_cnt_r, fill_cnt_nxt;
  logic [IdxW-1:0]        hand_r, hand_nxt;
  logic [MAX_SLOTS-1:0]   ref_r, ref_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic                   iref_r, iref_nxt;
  logic [IdxW-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic [IdxW-1:0]        pos_r, pos_nxt;
  logic [IdxW-1:0]        idx_r, idx_nxt;
  crp_pkg::res_kind_t     kind_r, kind_nxt;
  logic [KEY_BITS-1:0]    victim_r, victim_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic [SlotW-1:0]       out_slot_r, out_slot_nxt;
  logic                   out_evicted_r, out_evicted_nxt;
  logic [EvkW-1:0]        out_evk_r, out_evk_nxt;

  logic [CmpW-1:0]        cap_ext;
  logic [CmpW-1:0]        eff_cap;
  logic [CntW-1:0]        pos_inc;
  logic [IdxW-1:0]        pos_wrap;
  logic [IdxW-1:0]        hand_start;
  logic [IdxW-1:0]        ram_raddr;
  logic [KEY_BITS-1:0]    ram_rdata;
  logic                   ram_we;

  // Effective capacity: zero acts as one, anything above the slot count saturates.
  assign cap_ext = CmpW'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(MAX_SLOTS)) begin
      eff_cap = CmpW'(MAX_SLOTS);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Hand arithmetic wraps over the occupied slots only.
  assign pos_inc    = CntW'(pos_r) + CntW'(1);
  assign pos_wrap   = (pos_inc < fill_cnt_r) ? IdxW'(pos_inc) : '0;
  assign hand_start = (CntW'(hand_r) >= fill_cnt_r) ? '0 : hand_r;

  // Status back to the controller.
  assign stat.empty    = (fill_cnt_r == '0);
  assign stat.match    = (ram_rdata == key_r);
  assign stat.last     = ((CntW'(cmp_idx_r) + CntW'(1)) == fill_cnt_r);
  assign stat.room     = (CmpW'(fill_cnt_r) < eff_cap);
  assign stat.ref_set  = ref_r[pos_r];
  assign stat.out_free = !out_valid_r || out_ready;

  // Key RAM: read address follows the search, otherwise the sweep position.
  always_comb begin
    if (cmd.load) begin
      ram_raddr = '0;
    end else if (cmd.step) begin
      ram_raddr = cmp_idx_r + IdxW'(1);
    end else begin
      ram_raddr = pos_r;
    end
  end

  assign ram_we = cmd.commit && (kind_r != crp_pkg::KIND_HIT);

  crp_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (MAX_SLOTS),
    .ADDR_W(IdxW)
  ) u_key_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_r),
    .wdata(key_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Per-access working registers.
  always_comb begin
    key_nxt     = key_r;
    iref_nxt    = iref_r;
    cmp_idx_nxt = cmp_idx_r;
    pos_nxt     = pos_r;
    idx_nxt     = idx_r;
    kind_nxt    = kind_r;
    victim_nxt  = victim_r;
    if (cmd.load) begin
      key_nxt     = in_key;
      iref_nxt    = in_insert_ref;
      cmp_idx_nxt = '0;
    end
    if (cmd.step) begin
      cmp_idx_nxt = cmp_idx_r + IdxW'(1);
    end
    if (cmd.set_hit) begin
      kind_nxt = crp_pkg::KIND_HIT;
      idx_nxt  = cmp_idx_r;
    end
    if (cmd.set_fill) begin
      kind_nxt = crp_pkg::KIND_FILL;
      idx_nxt  = IdxW'(fill_cnt_r);
    end
    if (cmd.set_sweep) begin
      pos_nxt = hand_start;
    end
    if (cmd.clear_adv) begin
      pos_nxt = pos_wrap;
    end
    if (cmd.grab_victim) begin
      kind_nxt   = crp_pkg::KIND_EVICT;
      idx_nxt    = pos_r;
      victim_nxt = ram_rdata;
    end
  end

  // Replacement state: reference bits, fill count, hand and capacity.
  always_comb begin
    cap_nxt      = cap_r;
    fill_cnt_nxt = fill_cnt_r;
    hand_nxt     = hand_r;
    ref_nxt      = ref_r;
    if (cfg_we) begin
      cap_nxt = cfg_wdata;
    end
    if (cmd.clear_adv) begin
      ref_nxt[pos_r] = 1'b0;
    end
    if (cmd.commit) begin
      case (kind_r)
        crp_pkg::KIND_HIT: begin
          ref_nxt[idx_r] = 1'b1;
        end
        crp_pkg::KIND_FILL: begin
          ref_nxt[idx_r] = iref_r;
          fill_cnt_nxt   = fill_cnt_r + CntW'(1);
        end
        crp_pkg::KIND_EVICT: begin
          ref_nxt[idx_r] = iref_r;
          hand_nxt       = pos_wrap;
        end
        default: begin
          ref_nxt = ref_r;
        end
      endcase
    end
  end

  // Output register: loaded on commit, cleared once taken.
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_hit_nxt     = out_hit_r;
    out_slot_nxt    = out_slot_r;
    out_evicted_nxt = out_evicted_r;
    out_evk_nxt     = out_evk_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt   = 1'b1;
      out_hit_nxt     = (kind_r == crp_pkg::KIND_HIT);
      out_slot_nxt    = SlotW'(idx_r);
      out_evicted_nxt = (kind_r == crp_pkg::KIND_EVICT);
      out_evk_nxt     = (kind_r == crp_pkg::KIND_EVICT) ? EvkW'(victim_r) : '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= crp_pkg::CAP_RESET;
      fill_cnt_r  <= '0;
      hand_r      <= '0;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      hand_r      <= hand_nxt;
      ref_r       <= ref_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    iref_r        <= iref_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    pos_r         <= pos_nxt;
    idx_r         <= idx_nxt;
    kind_r        <= kind_nxt;
    victim_r      <= victim_nxt;
    out_hit_r     <= out_hit_nxt;
    out_slot_r    <= out_slot_nxt;
    out_evicted_r <= out_evicted_nxt;
    out_evk_r     <= out_evk_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_slot        = out_slot_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evk_r;

`ifndef SYNTH
  // The fill count never runs past the number of slots.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= CntW'(MAX_SLOTS))
    else $error("fill count exceeds slot count");

  // A result is only committed when the output register can take it.
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result committed over a pending word");

  // A hit always points at an occupied slot.
  a_hit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && kind_r == crp_pkg::KIND_HIT) |-> (CntW'(idx_r) < fill_cnt_r))
    else $error("hit on an unoccupied slot");

  // Replacement happens only when the block is full.
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && kind_r == crp_pkg::KIND_EVICT) |-> !stat.room)
    else $error("eviction while free slots remain");
`endif

endmodule

[tb/clock_page_replacement_test.sv]
// ----------------------------------------------------------------------------
// clock_page_replacement_test
// Self-checking bench for the clock page replacement block. A directed run
// covers key extremes, hits, fills, sweeps that clear every reference bit,
// capacity at and beyond its limits and capacity lowered under the fill
// level. Random runs follow at several capacities and handshake idling
// patterns. A local model of the slot table predicts each result word.
// ----------------------------------------------------------------------------
module clock_page_replacement_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS   = crp_pkg::MAX_SLOTS_DEF;
  localparam int KEY_W       = crp_pkg::KEY_BITS_DEF;
  localparam int POOL_SIZE   = 22;
  localparam int CYCLE_LIMIT = 500000;

  // One expected result word.
  typedef struct packed {
    logic                       hit;
    logic [crp_pkg::SLOT_W-1:0] slot;
    logic                       evicted;
    logic [crp_pkg::EVK_W-1:0]  evicted_key;
  } access_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      cfg_we;
  logic [crp_pkg::CAP_W-1:0] cfg_wdata;

  crp_in_if #(.KEY_W(KEY_W)) in_ch ();
  crp_out_if                 out_ch ();

  clock_page_replacement #(
    .MAX_SLOTS(NUM_SLOTS),
    .KEY_BITS (KEY_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Local copy of the slot table, hand and capacity.
  logic [KEY_W-1:0]          resident_key [NUM_SLOTS];
  logic                      second_chance[NUM_SLOTS];
  int                        occupied;
  int                        hand_pos;
  logic [crp_pkg::CAP_W-1:0] cap_setting;

  access_result_t pending_results[$];
  int             error_count = 0;
  int             cycle_count = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;

  always #6 clk = ~clk;

  // The run is cut off if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Works out the result of one access and updates the local table.
  function automatic access_result_t predict_access(logic [KEY_W-1:0] k, logic iref);
    access_result_t r;
    int             cap;
    int             n;
    int             pos;
    r   = '0;
    cap = (cap_setting == 0) ? 1 :
          ((int'(cap_setting) > NUM_SLOTS) ? NUM_SLOTS : int'(cap_setting));
    n   = occupied;
    for (int i = 0; i < n; i++) begin
      if (resident_key[i] == k) begin
        second_chance[i] = 1'b1;
        r.hit  = 1'b1;
        r.slot = crp_pkg::SLOT_W'(i);
        return r;
      end
    end
    // A free slot is filled in order.
    if (n < cap) begin
      resident_key[n]  = k;
      second_chance[n] = iref;
      occupied         = n + 1;
      r.slot           = crp_pkg::SLOT_W'(n);
      return r;
    end
    // Full: the hand clears set bits until it finds a clear one.
    pos = (hand_pos >= n) ? 0 : hand_pos;
    for (int i = 0; i < n && second_chance[pos]; i++) begin
      second_chance[pos] = 1'b0;
      pos = (pos + 1 < n) ? pos + 1 : 0;
    end
    r.slot             = crp_pkg::SLOT_W'(pos);
    r.evicted          = 1'b1;
    r.evicted_key      = crp_pkg::EVK_W'(resident_key[pos]);
    resident_key[pos]  = k;
    second_chance[pos] = iref;
    hand_pos           = (pos + 1 < n) ? pos + 1 : 0;
    return r;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Compares one accepted result word with the oldest expectation.
  task automatic check_result_word();
    access_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected word, evicted_key", 32'(out_ch.evicted_key), '0);
    end else begin
      want = pending_results.pop_front();
      if (out_ch.hit !== want.hit) begin
        report_mismatch("hit", 32'(out_ch.hit), 32'(want.hit));
      end
      if (out_ch.slot !== want.slot) begin
        report_mismatch("slot", 32'(out_ch.slot), 32'(want.slot));
      end
      if (out_ch.evicted !== want.evicted) begin
        report_mismatch("evicted", 32'(out_ch.evicted), 32'(want.evicted));
      end
      if (out_ch.evicted_key !== want.evicted_key) begin
        report_mismatch("evicted_key", 32'(out_ch.evicted_key), 32'(want.evicted_key));
      end
    end
  endtask

  // Result side: checks each accepted word and stalls at random.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        check_result_word();
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Sends one access word, with optional idle cycles before it.
  task automatic send_access(logic [KEY_W-1:0] k, logic iref);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.key        <= k;
    in_ch.insert_ref <= iref;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(predict_access(k, iref));
  endtask

  // Waits until every expected word has come back and the block is quiet.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Capacity is only changed with no access in flight.
  task automatic write_capacity(logic [crp_pkg::CAP_W-1:0] value);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    cap_setting  = value;
  endtask

  // Mostly keys from a small pool so that hits and sweeps are frequent.
  task automatic run_random_accesses(int count);
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    logic [KEY_W-1:0] k;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 75) k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else k = $urandom;
      send_access(k, 1'(($urandom_range(1))));
    end
  endtask

  // Directed cases: zero capacity, key extremes, full sweeps and wrap.
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Zero capacity behaves as one slot.
    write_capacity(5'd0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h0000_0000, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'hFFFF_FFFF, 1'b0);
    // Three slots: fill, then replace with partial sweeps.
    write_capacity(5'd3);
    send_access(32'hA5A5_A5A5, 1'b0);
    send_access(32'h5A5A_5A5A, 1'b1);
    send_access(32'h1234_5678, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    // Every reference bit set: the hand clears all of them and wraps.
    send_access(32'h1234_5678, 1'b0);
    send_access(32'h5A5A_5A5A, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hDEAD_BEEF, 1'b1);
    // Capacity above the slot count acts as the slot count.
    write_capacity(5'd31);
    send_access(32'h8000_0001, 1'b1);
    send_access(32'h7FFF_FFFE, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(32'hDEAD_BEEF, 1'b0);
    // Capacity lowered under the fill level: the block counts as full.
    write_capacity(5'd2);
    send_access(32'h0F0F_0F0F, 1'b0);
    send_access(32'hF0F0_F0F0, 1'b1);
    send_access(32'h8000_0001, 1'b0);
    send_access(32'h0000_0001, 1'b0);
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_streaming();
    write_capacity(5'd8);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_accesses(120);
  endtask

  // Sender leaves gaps; capacity at the slot count.
  task automatic test_sender_gaps();
    write_capacity(5'd16);
    send_idle_pct  = 45;
    recv_stall_pct = 0;
    run_random_accesses(120);
  endtask

  // Receiver stalls; capacity beyond the slot count.
  task automatic test_receiver_stalls();
    write_capacity(5'd20);
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    run_random_accesses(120);
  endtask

  // Both sides idle; capacity below the fill level.
  task automatic test_both_idle();
    write_capacity(5'd1);
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    run_random_accesses(120);
  endtask

  // Stimulus: reset once, then each test in turn.
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.key        = '0;
    in_ch.insert_ref = 1'b0;
    foreach (second_chance[i]) second_chance[i] = 1'b0;
    occupied    = 0;
    hand_pos    = 0;
    cap_setting = crp_pkg::CAP_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();

    wait_for_drain();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
